### design/bccd_pkg.sv
// Shared types and constants for the button click detector.
`default_nettype none
package bccd_pkg;

    // Widths fixed by the interface
    localparam int TS_W  = 32;
    localparam int CFG_W = 16;
    localparam int ACT_W = 2;
    localparam int IDX_W = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_SCAN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INIT = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DBL_CLICK = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MIN_PRESS = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 16'd10;
    localparam logic [CFG_W-1:0] RST_DBL_CLICK = 16'd250;
    localparam logic [CFG_W-1:0] RST_MIN_PRESS = 16'd5;

    // Command queue and result queue sizes
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_AW     = 1;
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_AW     = 1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [1:0]       pressed;   // active high, bit i = button i
        logic [TS_W-1:0]  now;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] dbl_click;
        logic [CFG_W-1:0] min_press;
    } t_cfg;

    // Per-button control from the back end
    typedef struct packed {
        logic scan;
        logic init;
    } t_btn_ctl;

    // Event request from one button
    typedef struct packed {
        logic push;
        logic kind;   // 0 short press, 1 double click
    } t_ev;

endpackage
`default_nettype wire

### design/button_click_double_click_detector.sv
// Top level of the two-button debounce and click detector.
//
//  channel  direction  transfer when          payload
//  -------  ---------  ---------------------  --------------------------------------
//  input    in         push & !full           i_action, i_pin_level_0/1, i_now_ms
//  result   out        pop & !empty           o_event_valid, o_button_index, o_click_kind
//  config   in         i_cfg_valid & ready    i_cfg_index, i_cfg_data
//
// One item per cycle sustained while full stays low. A command waits in the front queue
// and executes from its head; a pop's ring read passes the read stage register into the
// result queue, from whose head it can be taken with pop high and empty low.
// When both buttons emit events in one scan, the second waits in the pending register and
// holds the back end (the ring memory takes one write per cycle). Reset is synchronous,
// active low, and needs no clearing pass. full stalls only when the two-entry command
// queue backs up; pops stall in the back end while the result queue has no room.
`default_nettype none
module button_click_double_click_detector #(
    parameter int RING_DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [bccd_pkg::ACT_W-1:0] i_action,
    input  wire logic                       i_pin_level_0,
    input  wire logic                       i_pin_level_1,
    input  wire logic [bccd_pkg::TS_W-1:0]  i_now_ms,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_event_valid,
    output logic                            o_button_index,
    output logic                            o_click_kind,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [bccd_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [bccd_pkg::CFG_W-1:0] i_cfg_data
);

    bccd_pkg::t_cfg     r_cfg;
    bccd_pkg::t_cmd     cmd;
    bccd_pkg::t_btn_ctl ctl;
    bccd_pkg::t_ev      ev0, ev1;
    logic               cmd_valid, cmd_ready;

    // Configuration: always ready, writes to unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= bccd_pkg::RST_DEBOUNCE;
            r_cfg.dbl_click <= bccd_pkg::RST_DBL_CLICK;
            r_cfg.min_press <= bccd_pkg::RST_MIN_PRESS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bccd_pkg::CFG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data;
                bccd_pkg::CFG_DBL_CLICK: r_cfg.dbl_click <= i_cfg_data;
                bccd_pkg::CFG_MIN_PRESS: r_cfg.min_press <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Front: accept and classify items, queue them for the back end.
    bccd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_pin_level_0 (i_pin_level_0),
        .i_pin_level_1 (i_pin_level_1),
        .i_now_ms      (i_now_ms),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_ready   (cmd_ready)
    );

    // Button state: both buttons update in the same cycle; the back end
    // orders their events with button 0 first.
    bccd_btn u_btn0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_pressed (cmd.pressed[0]),
        .i_now     (cmd.now),
        .o_ev      (ev0)
    );

    bccd_btn u_btn1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_cfg     (r_cfg),
        .i_pressed (cmd.pressed[1]),
        .i_now     (cmd.now),
        .o_ev      (ev1)
    );

    // Back: event ring, pop reads and the result queue.
    bccd_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_ready    (cmd_ready),
        .i_ev0          (ev0),
        .i_ev1          (ev1),
        .o_ctl          (ctl),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_event_valid  (o_event_valid),
        .o_button_index (o_button_index),
        .o_click_kind   (o_click_kind)
    );

endmodule
`default_nettype wire

### design/bccd_front.sv
// Front end: accepts input items, drops unused actions, queues commands.
`default_nettype none
module bccd_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [bccd_pkg::ACT_W-1:0] i_action,
    input  wire logic                  i_pin_level_0,
    input  wire logic                  i_pin_level_1,
    input  wire logic [bccd_pkg::TS_W-1:0]  i_now_ms,
    output logic                       o_cmd_valid,
    output bccd_pkg::t_cmd             o_cmd,
    input  wire logic                  i_cmd_ready
);

    bccd_pkg::t_cmd r_q [bccd_pkg::CQ_DEPTH];
    logic [bccd_pkg::CQ_AW-1:0] r_wp, r_rp;
    logic [bccd_pkg::CQ_AW:0]   r_cnt, n_cnt;
    logic                       known, enq, deq;
    bccd_pkg::t_cmd             cmd_in;

    always_comb begin
        known = (i_action == bccd_pkg::ACT_SCAN) || (i_action == bccd_pkg::ACT_POP) ||
                (i_action == bccd_pkg::ACT_INIT);
        cmd_in.action  = i_action;
        cmd_in.pressed = {~i_pin_level_1, ~i_pin_level_0};
        cmd_in.now     = i_now_ms;
    end

    assign o_full      = (r_cnt == (bccd_pkg::CQ_AW + 1)'(bccd_pkg::CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    // drop unused action codes at the door
    assign enq = i_push && !o_full && known;
    assign deq = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt + {{bccd_pkg::CQ_AW{1'b0}}, enq} - {{bccd_pkg::CQ_AW{1'b0}}, deq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

### design/bccd_btn.sv
// Per-button debounce and click classification.
`default_nettype none
module bccd_btn (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  bccd_pkg::t_btn_ctl             i_ctl,
    input  bccd_pkg::t_cfg                 i_cfg,
    input  wire logic                      i_pressed,
    input  wire logic [bccd_pkg::TS_W-1:0] i_now,
    output bccd_pkg::t_ev                  o_ev
);

    localparam int PAD = bccd_pkg::TS_W - bccd_pkg::CFG_W;

    logic r_raw, r_stable, r_pending;
    logic n_stable, n_pending;
    logic [bccd_pkg::TS_W-1:0] r_raw_time, r_press_time, r_click_time;
    logic [bccd_pkg::TS_W-1:0] n_press_time, n_click_time;
    logic [bccd_pkg::TS_W-1:0] t_raw, d_raw, d_press, d_click;
    logic raw_chg, stable_chg, long_hold, in_window, click_set;

    always_comb begin
        raw_chg    = (i_pressed != r_raw);
        t_raw      = raw_chg ? i_now : r_raw_time;
        d_raw      = i_now - t_raw;
        d_press    = i_now - r_press_time;
        d_click    = i_now - r_click_time;
        stable_chg = (d_raw >= {{PAD{1'b0}}, i_cfg.debounce}) && (r_stable != i_pressed);
        long_hold  = (d_press >= {{PAD{1'b0}}, i_cfg.min_press});
        in_window  = (d_click <= {{PAD{1'b0}}, i_cfg.dbl_click});

        n_stable     = r_stable;
        n_pending    = r_pending;
        n_press_time = r_press_time;
        n_click_time = r_click_time;
        click_set    = 1'b0;
        o_ev         = '0;

        if (stable_chg) begin
            n_stable = i_pressed;
            if (i_pressed) begin
                n_press_time = i_now;
            end else if (long_hold) begin
                o_ev.push = 1'b1;
                if (r_pending && in_window) begin
                    o_ev.kind = 1'b1;
                    n_pending = 1'b0;
                end else begin
                    o_ev.kind    = 1'b0;
                    n_pending    = 1'b1;
                    n_click_time = i_now;
                    click_set    = 1'b1;
                end
            end else begin
                n_pending = 1'b0;
            end
        end
        // expire a pending click that is past the window
        if (n_pending && !click_set && !in_window) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw        <= 1'b0;
            r_stable     <= 1'b0;
            r_pending    <= 1'b0;
            r_raw_time   <= '0;
            r_press_time <= '0;
            r_click_time <= '0;
        end else if (i_ctl.init) begin
            r_raw        <= i_pressed;
            r_stable     <= i_pressed;
            r_pending    <= 1'b0;
            r_raw_time   <= i_now;
            r_press_time <= '0;
            r_click_time <= '0;
        end else if (i_ctl.scan) begin
            r_raw        <= i_pressed;
            r_stable     <= n_stable;
            r_pending    <= n_pending;
            r_raw_time   <= t_raw;
            r_press_time <= n_press_time;
            r_click_time <= n_click_time;
        end
    end

endmodule
`default_nettype wire

### design/bccd_back.sv
// Back end: executes commands, owns the event ring and the result queue.
`default_nettype none
module bccd_back #(
    parameter int RING_DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  bccd_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    input  bccd_pkg::t_ev   i_ev0,
    input  bccd_pkg::t_ev   i_ev1,
    output bccd_pkg::t_btn_ctl o_ctl,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic            o_event_valid,
    output logic            o_button_index,
    output logic            o_click_kind
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);
    localparam int CW = bccd_pkg::OQ_AW + 1;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    logic is_scan, is_pop, is_init, take, credit, ring_hit, out_pop;
    logic wr_en;
    logic [1:0] wr_data;   // bit0 button, bit1 kind
    logic [PW-1:0] r_head, r_tail, n_head, n_tail, head_nx;
    logic r_pend_valid, n_pend_valid, r_pend_kind, n_pend_kind;
    logic [1:0] r_ring [RING_DEPTH];
    logic [1:0] r_rd_data;
    logic r_rd_valid, r_rd_hit;
    logic [2:0] r_oq [bccd_pkg::OQ_DEPTH];   // {valid, kind, button}
    logic [bccd_pkg::OQ_AW-1:0] r_oq_wp, r_oq_rp;
    logic [CW-1:0] r_oq_cnt;

    always_comb begin
        is_scan = (i_cmd.action == bccd_pkg::ACT_SCAN);
        is_pop  = (i_cmd.action == bccd_pkg::ACT_POP);
        is_init = (i_cmd.action == bccd_pkg::ACT_INIT);
        out_pop = i_pop && !o_empty;
        // room for a result counting the one in the read stage
        credit  = ({1'b0, r_oq_cnt} + {{CW{1'b0}}, r_rd_valid}) <
                  ((CW + 1)'(bccd_pkg::OQ_DEPTH) + {{CW{1'b0}}, out_pop});
        o_cmd_ready = !r_pend_valid && (!is_pop || credit);
        take        = i_cmd_valid && o_cmd_ready;
        o_ctl.scan  = take && is_scan;
        o_ctl.init  = take && is_init;
    end

    // ring write: button 0 first, a second event waits in the pending register
    always_comb begin
        wr_en        = 1'b0;
        wr_data      = '0;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        priority if (r_pend_valid) begin
            wr_en        = 1'b1;
            wr_data      = {r_pend_kind, 1'b1};
            n_pend_valid = 1'b0;
        end else if (o_ctl.scan && i_ev0.push) begin
            wr_en        = 1'b1;
            wr_data      = {i_ev0.kind, 1'b0};
            n_pend_valid = i_ev1.push;
            n_pend_kind  = i_ev1.kind;
        end else if (o_ctl.scan && i_ev1.push) begin
            wr_en   = 1'b1;
            wr_data = {i_ev1.kind, 1'b1};
        end else begin
            wr_en = 1'b0;
        end
    end

    always_comb begin
        ring_hit = (r_head != r_tail);
        head_nx  = ring_next(r_head);
        n_head   = r_head;
        n_tail   = r_tail;
        priority if (o_ctl.init) begin
            n_head = '0;
            n_tail = '0;
        end else if (wr_en) begin
            n_head = head_nx;
            if (head_nx == r_tail) begin
                n_tail = ring_next(r_tail);   // drop the oldest event
            end
        end else if (take && is_pop && ring_hit) begin
            n_tail = ring_next(r_tail);
        end else begin
            n_head = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_pend_valid <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_oq_wp      <= '0;
            r_oq_rp      <= '0;
            r_oq_cnt     <= '0;
        end else begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_pend_valid <= n_pend_valid;
            r_rd_valid   <= take && is_pop;
            if (r_rd_valid) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (out_pop) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + {{(CW-1){1'b0}}, r_rd_valid} - {{(CW-1){1'b0}}, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_kind <= n_pend_kind;
        r_rd_hit    <= ring_hit;
        if (wr_en) begin
            r_ring[r_head] <= wr_data;
        end
        if (take && is_pop) begin
            r_rd_data <= r_ring[r_tail];
        end
        if (r_rd_valid) begin
            r_oq[r_oq_wp] <= {r_rd_hit, r_rd_hit & r_rd_data[1], r_rd_hit & r_rd_data[0]};
        end
    end

    assign o_empty        = (r_oq_cnt == '0);
    assign o_event_valid  = r_oq[r_oq_rp][2];
    assign o_click_kind   = r_oq[r_oq_rp][1];
    assign o_button_index = r_oq[r_oq_rp][0];

    a_pend_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |=> !r_pend_valid)
        else $error("second ring write held more than one cycle");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= CW'(bccd_pkg::OQ_DEPTH))
        else $error("result queue count out of range");

    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_oq_cnt < CW'(bccd_pkg::OQ_DEPTH) || out_pop))
        else $error("read result arrives at a full result queue");

    a_ring_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_head != r_tail))
        else $error("ring empty right after an event write");

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the two-button debounce and click detector, with a click predictor and scoreboard.
module tb;
    import bccd_pkg::*;

    localparam int RING_N      = 8;       // ring slots; one stays unused, so seven events fit
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;      // covers queue, execute and result latency
    localparam int PHASES      = 8;
    localparam int ITEM_GOAL   = 800;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;   // unused action code, ignored by the block

    typedef struct {
        logic [ACT_W-1:0] act;
        logic             lvl0;
        logic             lvl1;
        logic [TS_W-1:0]  ts;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic btn;
        logic kind;
    } click_evt_t;

    // Clock, reset and block ports; every input starts at a known value
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               push          = 1'b0;
    logic               full;
    logic [ACT_W-1:0]   i_action      = ACT_SCAN;
    logic               i_pin_level_0 = 1'b1;
    logic               i_pin_level_1 = 1'b1;
    logic [TS_W-1:0]    i_now_ms      = '0;
    logic               empty;
    logic               pop           = 1'b0;
    logic               o_event_valid;
    logic               o_button_index;
    logic               o_click_kind;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index   = CFG_DEBOUNCE;
    logic [CFG_W-1:0]   i_cfg_data    = '0;

    button_click_double_click_detector i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_pin_level_0  (i_pin_level_0),
        .i_pin_level_1  (i_pin_level_1),
        .i_now_ms       (i_now_ms),
        .empty          (empty),
        .pop            (pop),
        .o_event_valid  (o_event_valid),
        .o_button_index (o_button_index),
        .o_click_kind   (o_click_kind),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Click predictor: its own copy of the button state, ring and registers.
    // Button state is kept active high ("down" = pressed).
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_debounce = RST_DEBOUNCE;
    logic [CFG_W-1:0] cfg_window   = RST_DBL_CLICK;
    logic [CFG_W-1:0] cfg_min_hold = RST_MIN_PRESS;

    logic [1:0]       raw_dn   = '0;
    logic [1:0]       stab_dn  = '0;
    logic [1:0]       armed    = '0;
    logic [TS_W-1:0]  chg_ts   [2] = '{default: '0};
    logic [TS_W-1:0]  press_ts [2] = '{default: '0};
    logic [TS_W-1:0]  click_ts [2] = '{default: '0};
    logic [1:0]       ring_mem [RING_N];        // bit 0 button, bit 1 kind
    int               wr_ptr = 0;
    int               rd_ptr = 0;

    click_evt_t       expected_events[$];
    int               mismatches = 0;

    // Store one event; a full ring drops its oldest entry first
    task automatic ring_put(input int b, input logic kind);
        int nxt;
        nxt = (wr_ptr + 1) % RING_N;
        if (nxt == rd_ptr) begin
            rd_ptr = (rd_ptr + 1) % RING_N;
        end
        ring_mem[wr_ptr] = {kind, b[0]};
        wr_ptr = nxt;
    endtask

    task automatic scan_button(input int b, input logic down, input logic [TS_W-1:0] ts);
        logic [TS_W-1:0] age;
        logic [TS_W-1:0] held;
        logic [TS_W-1:0] since;
        if (down != raw_dn[b]) begin
            raw_dn[b] = down;
            chg_ts[b] = ts;
        end
        age = ts - chg_ts[b];
        if (age >= {16'd0, cfg_debounce} && stab_dn[b] != raw_dn[b]) begin
            stab_dn[b] = raw_dn[b];
            held  = ts - press_ts[b];
            since = ts - click_ts[b];
            if (stab_dn[b]) begin
                press_ts[b] = ts;
            end else if (held >= {16'd0, cfg_min_hold}) begin
                // a real click: pair it with a pending one, or arm a new one
                if (armed[b] && since <= {16'd0, cfg_window}) begin
                    ring_put(b, 1'b1);
                    armed[b] = 1'b0;
                end else begin
                    ring_put(b, 1'b0);
                    armed[b]    = 1'b1;
                    click_ts[b] = ts;
                end
            end else begin
                // too short to be a click: cancel whatever was pending
                armed[b] = 1'b0;
            end
        end
        since = ts - click_ts[b];
        if (armed[b] && since > {16'd0, cfg_window}) begin
            armed[b] = 1'b0;
        end
    endtask

    // Advance the predictor by one accepted command
    task automatic predict_clicks(input cmd_t c);
        logic [1:0] ent;
        case (c.act)
            ACT_SCAN: begin
                scan_button(0, ~c.lvl0, c.ts);
                scan_button(1, ~c.lvl1, c.ts);
            end
            ACT_POP: begin
                if (rd_ptr == wr_ptr) begin
                    expected_events.push_back(click_evt_t'('0));
                end else begin
                    ent = ring_mem[rd_ptr];
                    expected_events.push_back({1'b1, ent[0], ent[1]});
                    rd_ptr = (rd_ptr + 1) % RING_N;
                end
            end
            ACT_INIT: begin
                raw_dn  = {~c.lvl1, ~c.lvl0};
                stab_dn = raw_dn;
                armed   = '0;
                for (int b = 0; b < 2; b++) begin
                    chg_ts[b]   = c.ts;
                    press_ts[b] = '0;
                    click_ts[b] = '0;
                end
                wr_ptr = 0;
                rd_ptr = 0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: pull commands from the pending queue, in bursts with gaps.
    // A command is transferred at an edge with push high and full low.
    // ------------------------------------------------------------------
    cmd_t pending_cmds[$];
    cmd_t cur_cmd;
    int   cmds_in_flight = 0;
    int   burst_left     = 0;
    int   gap_left       = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            // the command on the ports was transferred at this edge
            if (push) begin
                predict_clicks(cur_cmd);
                cmds_in_flight--;
            end
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur_cmd        = pending_cmds.pop_front();
                push          <= 1'b1;
                i_action      <= cur_cmd.act;
                i_pin_level_0 <= cur_cmd.lvl0;
                i_pin_level_1 <= cur_cmd.lvl1;
                i_now_ms      <= cur_cmd.ts;
                // end of a burst: draw the next burst length and the gap before it
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pop follows a rotating stall pattern, redrawn every lap.
    // ------------------------------------------------------------------
    logic [15:0] stall_pat = '0;
    int          stall_pos = 0;

    always @(posedge i_clk) begin
        if (stall_pos == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pat = 16'h0000;                       // no stalls this lap
                2:       stall_pat = 16'($urandom);
                3:       stall_pat = 16'($urandom) & 16'($urandom);
                default: stall_pat = 16'hFF00;                       // one long stall
            endcase
        end
        pop      <= ~stall_pat[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
    end

    // ------------------------------------------------------------------
    // Monitor: check each transferred result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        click_evt_t got;
        click_evt_t want;
        if (i_rst_n && pop && !empty) begin
            got = {o_event_valid, o_button_index, o_click_kind};
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, none expected, got valid=%b button=%b kind=%b",
                         $time, got.valid, got.btn, got.kind);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                if (got !== want) begin
                    $display("%0t: event mismatch: expected valid=%b button=%b kind=%b, got valid=%b button=%b kind=%b",
                             $time, want.valid, want.btn, want.kind,
                             got.valid, got.btn, got.kind);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    logic [TS_W-1:0] gen_t    = '0;     // timeline of the generated scans
    logic [1:0]      gen_pins = 2'b11;  // raw pin levels, bit b for button b, 0 = pressed
    int              stim_cnt = 0;

    task automatic add_cmd(input logic [ACT_W-1:0] act, input logic [1:0] pins,
                           input logic [TS_W-1:0] ts);
        pending_cmds.push_back('{act, pins[0], pins[1], ts});
        cmds_in_flight++;
        if (act != ACT_NONE) begin
            stim_cnt++;
        end
    endtask

    task automatic scan_at(input logic [TS_W-1:0] ts);
        gen_t = ts;
        add_cmd(ACT_SCAN, gen_pins, ts);
    endtask

    // Scan around the debounce boundary of a change at t_chg; sometimes one ms short first
    task automatic settle(input logic [TS_W-1:0] t_chg);
        int unsigned db;
        db = cfg_debounce;
        if (db > 0 && $urandom_range(0, 3) == 0) begin
            scan_at(t_chg + db - 1);
        end
        scan_at(t_chg + db + $urandom_range(0, 1));
    endtask

    // One press and release of the buttons in which, timed around the
    // minimum hold and the double-click window
    task automatic click_gesture(input logic [1:0] which);
        int unsigned     db;
        int unsigned     hold;
        int unsigned     lead;
        int              aim;
        logic [TS_W-1:0] rel_t;
        db = cfg_debounce;
        case ($urandom_range(0, 4))
            0:       hold = (cfg_min_hold > 0) ? cfg_min_hold - 1 : 0;
            1:       hold = cfg_min_hold;
            2:       hold = cfg_min_hold + 1;
            3:       hold = cfg_min_hold + $urandom_range(0, 60);
            default: hold = $urandom_range(0, cfg_min_hold);
        endcase
        // release-to-release span is roughly lead + debounce + hold
        case ($urandom_range(0, 3))
            0: begin
                aim  = int'(cfg_window) - int'(db) - int'(hold)
                       + int'($urandom_range(0, 2)) - 1;
                lead = (aim < 0) ? 0 : aim;
            end
            1:       lead = $urandom_range(0, cfg_window);
            2:       lead = cfg_window + $urandom_range(1, 100);
            default: lead = $urandom_range(0, 5);
        endcase
        // contact bounce on the press edge now and then
        if ($urandom_range(0, 3) == 0) begin
            gen_pins &= ~which;
            scan_at(gen_t + lead);
            gen_pins |= which;
            scan_at(gen_t + $urandom_range(0, db));
            lead = $urandom_range(0, db);
        end
        gen_pins &= ~which;
        scan_at(gen_t + lead);
        settle(gen_t);
        // held: up to two scans, then the release edge
        rel_t = gen_t + ((hold > db) ? hold - db : 0);
        repeat ($urandom_range(0, 2)) begin
            scan_at(gen_t + $urandom_range(0, rel_t - gen_t));
        end
        gen_pins |= which;
        scan_at(rel_t);
        settle(gen_t);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:  cfg_debounce = val;
            CFG_DBL_CLICK: cfg_window   = val;
            CFG_MIN_PRESS: cfg_min_hold = val;
            default: ;
        endcase
    endtask

    // Hold until every command is transferred and every result has come back,
    // then let the pipeline drain
    task automatic wait_idle();
        while (cmds_in_flight != 0 || expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        int unsigned      r;
        int               phase_end;
        logic [1:0]       which;
        logic [CFG_W-1:0] s_db;
        logic [CFG_W-1:0] s_win;
        logic [CFG_W-1:0] s_min;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values
        add_cmd(ACT_POP,  2'b11, 32'd0);            // pop on an empty ring
        add_cmd(ACT_NONE, 2'b00, 32'hFFFF_FFFF);    // unused action code
        add_cmd(ACT_INIT, 2'b11, 32'd0);
        add_cmd(ACT_SCAN, 2'b00, 32'hFFFF_FFFF);    // both pressed just before the wrap
        add_cmd(ACT_SCAN, 2'b00, 32'd9);            // debounce completes across the wrap
        add_cmd(ACT_SCAN, 2'b11, 32'd20);
        add_cmd(ACT_SCAN, 2'b11, 32'd30);           // two short presses from one scan
        add_cmd(ACT_SCAN, 2'b10, 32'd40);
        add_cmd(ACT_SCAN, 2'b10, 32'd50);
        add_cmd(ACT_SCAN, 2'b11, 32'd60);
        add_cmd(ACT_SCAN, 2'b11, 32'd70);           // double click on button 0
        add_cmd(ACT_SCAN, 2'b11, 32'd281);          // pending click of button 1 expires
        add_cmd(ACT_SCAN, 2'b01, 32'd290);
        add_cmd(ACT_SCAN, 2'b01, 32'd300);
        add_cmd(ACT_SCAN, 2'b11, 32'd310);
        add_cmd(ACT_SCAN, 2'b11, 32'd320);          // short press again, not a double
        repeat (5) add_cmd(ACT_POP, 2'b00, 32'hFFFF_FFFF);  // four events, then empty
        add_cmd(ACT_INIT, 2'b10, 32'd500);          // button 0 already down at init
        gen_pins = 2'b10;
        gen_t    = 32'd500;

        // Random part, in phases with different register settings
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            if (p > 0) begin
                case (p)
                    1: begin s_db = '0;      s_win = '0;      s_min = '0;      end
                    2: begin s_db = '1;      s_win = '1;      s_min = '1;      end
                    3: begin s_db = 16'd3;   s_win = 16'd20;  s_min = 16'd12;  end
                    4: begin s_db = '0;      s_win = '1;      s_min = '1;      end
                    5: begin
                        s_db  = $urandom_range(0, 15);
                        s_win = $urandom_range(0, 300);
                        s_min = $urandom_range(0, 40);
                    end
                    6: begin
                        s_db  = 16'($urandom);
                        s_win = 16'($urandom);
                        s_min = 16'($urandom);
                    end
                    default: begin
                        s_db = RST_DEBOUNCE; s_win = RST_DBL_CLICK; s_min = RST_MIN_PRESS;
                    end
                endcase
                write_reg(CFG_DEBOUNCE,  s_db);
                write_reg(CFG_DBL_CLICK, s_win);
                write_reg(CFG_MIN_PRESS, s_min);
            end
            // sometimes run the phase across the timestamp wrap
            if ($urandom_range(0, 1) == 0) begin
                gen_t = 32'hFFFF_FFFF - $urandom_range(0, 300000);
            end
            phase_end = stim_cnt + ITEM_GOAL / PHASES;
            while (stim_cnt < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    which = ($urandom_range(0, 5) == 0) ? 2'b11 :
                            ($urandom_range(0, 1) ? 2'b10 : 2'b01);
                    click_gesture(which);
                end else if (r < 76) begin
                    repeat ($urandom_range(1, 5)) add_cmd(ACT_POP, 2'($urandom), $urandom);
                end else if (r < 88) begin
                    // noise: random levels, short steps or arbitrary jumps in time
                    repeat ($urandom_range(1, 4)) begin
                        gen_pins = 2'($urandom);
                        if ($urandom_range(0, 1) == 0) begin
                            scan_at(gen_t + $urandom_range(0, 2 * cfg_debounce + 2));
                        end else begin
                            scan_at($urandom);
                        end
                    end
                end else if (r < 93) begin
                    gen_pins = 2'($urandom);
                    gen_t   += $urandom_range(0, 50);
                    add_cmd(ACT_INIT, gen_pins, gen_t);
                end else if (r < 97) begin
                    // fill the ring past capacity, then drain it
                    repeat (5) click_gesture(2'b11);
                    repeat (8) add_cmd(ACT_POP, 2'($urandom), $urandom);
                end else begin
                    add_cmd(ACT_NONE, 2'($urandom), $urandom);
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
